/* rtl/uer_pkg.sv */
package uer_pkg;

	localparam int CMD_W   = 2;
	localparam int PHASE_W = 3;
	localparam int TICK_W  = 16;
	localparam int US_W    = 20;

	localparam logic [CMD_W-1:0] CMD_NONE    = 2'd0;
	localparam logic [CMD_W-1:0] CMD_START   = 2'd1;
	localparam logic [CMD_W-1:0] CMD_COLLECT = 2'd2;

	localparam logic [PHASE_W-1:0] PH_IDLE    = 3'd0;
	localparam logic [PHASE_W-1:0] PH_TRIG    = 3'd1;
	localparam logic [PHASE_W-1:0] PH_WAIT    = 3'd2;
	localparam logic [PHASE_W-1:0] PH_ECHO    = 3'd3;
	localparam logic [PHASE_W-1:0] PH_READY   = 3'd4;
	localparam logic [PHASE_W-1:0] PH_TIMEOUT = 3'd5;

	localparam logic [1:0] REG_TRIGGER_TICKS = 2'd0;
	localparam logic [1:0] REG_TIMEOUT_TICKS = 2'd1;
	localparam logic [1:0] REG_TICK_US       = 2'd2;

	localparam logic [7:0]  TRIGGER_TICKS_RST = 8'd3;
	localparam logic [15:0] TIMEOUT_TICKS_RST = 16'd10000;
	localparam logic [3:0]  TICK_US_RST       = 4'd4;

	typedef struct packed {
		logic [7:0]  trigger_ticks;
		logic [15:0] timeout_ticks;
		logic [3:0]  tick_us;
	} cfg_t;

	// Result word, first field in the highest bits.
	typedef struct packed {
		logic [US_W-1:0]    echo_us;
		logic               collect_ok;
		logic [PHASE_W-1:0] phase;
		logic               trig_level;
	} result_t;

	typedef struct packed {
		logic             echo_level;
		logic [CMD_W-1:0] cmd;
	} item_t;

endpackage

/* rtl/ultrasonic_echo_ranging_fsm.sv */
// The result word for an input word appears on the cycle after it is taken.
// Throughput: one word per cycle while the sink takes results; the phase update and the 16x4 width multiply sit
// between the phase registers and the output register.
// Reset (arst_n low, asynchronous): phase idle, tick count and stored width zero,
// trigger low, output empty, registers back to 3 / 10000 / 4.
module ultrasonic_echo_ranging_fsm (
	input  logic        clk,
	input  logic        arst_n,
	// input stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [1:0] cmd, [2] echo_level, [7:3] zero
	// result stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // [0] trig_level, [3:1] phase, [4] collect_ok,
	                               // [24:5] echo_us, [31:25] zero
	// register writes
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);
	import uer_pkg::*;

	cfg_t    cfg_q;
	item_t   item;
	result_t result;
	result_t out_q;
	logic    out_valid_q;
	logic    accept;

	// Register file: the user writes only while the block is quiet (not enforced); taken at once.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.trigger_ticks <= TRIGGER_TICKS_RST;
			cfg_q.timeout_ticks <= TIMEOUT_TICKS_RST;
			cfg_q.tick_us       <= TICK_US_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_TRIGGER_TICKS: cfg_q.trigger_ticks <= cfg_data[7:0];
				REG_TIMEOUT_TICKS: cfg_q.timeout_ticks <= cfg_data;
				REG_TICK_US:       cfg_q.tick_us       <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	// Take a new word whenever the output register is empty or being drained.
	assign s_tready = !out_valid_q || m_tready;
	assign accept   = s_tvalid && s_tready;
	assign item     = s_tdata[2:0];

	uer_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.advance(accept),
		.item   (item),
		.cfg    (cfg_q),
		.result (result)
	);

	// Output register: hold the word until the sink takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			out_q <= result;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {7'd0, out_q};

	// An empty output register never blocks the input side.
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid_q |-> s_tready)
		else $error("input stalled with empty output register");

	// A collected measurement always drops the block back to idle.
	a_collect_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.collect_ok) |-> (out_q.phase == PH_IDLE))
		else $error("collect_ok outside idle");

	// Trigger is driven only in the trigger phase.
	a_trig_phase: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.trig_level) |-> (out_q.phase == PH_TRIG))
		else $error("trigger high outside trigger phase");

	// A width is only reported with collect_ok.
	a_value_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_q.collect_ok) |-> (out_q.echo_us == '0))
		else $error("echo_us nonzero without collect_ok");

endmodule

/* rtl/uer_ctrl.sv */
module uer_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             advance,
	input  uer_pkg::item_t   item,
	input  uer_pkg::cfg_t    cfg,
	output uer_pkg::result_t result
);
	import uer_pkg::*;

	typedef enum logic [PHASE_W-1:0] {
		IDLE    = PH_IDLE,
		TRIG    = PH_TRIG,
		WAIT    = PH_WAIT,
		ECHO    = PH_ECHO,
		READY   = PH_READY,
		TIMEOUT = PH_TIMEOUT
	} phase_t;

	phase_t            phase_q, phase_d;
	logic [TICK_W-1:0] elapsed_q, elapsed_d, elapsed_inc;
	logic [US_W-1:0]   meas_q, meas_d;
	logic              trig_q, trig_d;
	logic              ok;
	logic [US_W-1:0]   value;

	// saturating tick count
	assign elapsed_inc = (&elapsed_q) ? elapsed_q : elapsed_q + TICK_W'(1);

	always_comb begin
		phase_d   = phase_q;
		elapsed_d = elapsed_q;
		meas_d    = meas_q;
		trig_d    = trig_q;
		ok        = 1'b0;
		value     = '0;

		case (phase_q)
			TRIG: begin
				elapsed_d = elapsed_inc;
				if (elapsed_inc >= {8'd0, cfg.trigger_ticks}) begin
					trig_d    = 1'b0;
					elapsed_d = '0;
					phase_d   = WAIT;
				end
			end
			WAIT: begin
				elapsed_d = elapsed_inc;
				if (item.echo_level) begin
					elapsed_d = '0;
					phase_d   = ECHO;
				end else if (elapsed_inc >= cfg.timeout_ticks) begin
					trig_d  = 1'b0;
					phase_d = TIMEOUT;
				end
			end
			ECHO: begin
				elapsed_d = elapsed_inc;
				if (!item.echo_level) begin
					meas_d  = US_W'(elapsed_inc) * US_W'(cfg.tick_us);
					phase_d = READY;
				end else if (elapsed_inc >= cfg.timeout_ticks) begin
					phase_d = TIMEOUT;
				end
			end
			default: ;
		endcase

		// command acts on the phase after the tick update
		case (item.cmd)
			CMD_START: begin
				if (phase_d == IDLE) begin
					meas_d    = '0;
					elapsed_d = '0;
					trig_d    = 1'b1;
					phase_d   = TRIG;
				end
			end
			CMD_COLLECT: begin
				if (phase_d == READY) begin
					ok      = 1'b1;
					value   = meas_d;
					phase_d = IDLE;
				end else if (phase_d == TIMEOUT) begin
					phase_d = IDLE;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= IDLE;
			elapsed_q <= '0;
			meas_q    <= '0;
			trig_q    <= 1'b0;
		end else if (advance) begin
			phase_q   <= phase_d;
			elapsed_q <= elapsed_d;
			meas_q    <= meas_d;
			trig_q    <= trig_d;
		end
	end

	assign result.trig_level = trig_d;
	assign result.phase      = phase_d;
	assign result.collect_ok = ok;
	assign result.echo_us    = value;

endmodule

/* tb/sv/echo_ranging_checker.sv */
// Watches both word streams and the register port, keeps its own copy of the
// ranging phase machine and compares every result word with the prediction.
module echo_ranging_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [7:0]  s_tdata,   // [1:0] cmd, [2] echo_level
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [31:0] m_tdata,   // [0] trig_level, [3:1] phase, [4] collect_ok, [24:5] echo_us
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data,
	output int          mismatches,
	output int          readings_due
);
	import uer_pkg::*;

	cfg_t               regs_q;
	logic [PHASE_W-1:0] phase_q;
	logic [TICK_W-1:0]  ticks_q;
	logic [US_W-1:0]    width_us_q;
	logic               trig_q;
	int                 words_seen;
	result_t            pending_readings[$];

	function automatic logic [TICK_W-1:0] sat_inc(input logic [TICK_W-1:0] v);
		return (v == '1) ? v : v + 1'b1;
	endfunction

	// Advance the mirrored phase machine by one tick, then apply the command.
	function automatic result_t predict_reading(input item_t w);
		result_t r;
		r = '0;
		case (phase_q)
			PH_TRIG: begin
				ticks_q = sat_inc(ticks_q);
				if (ticks_q >= regs_q.trigger_ticks) begin
					trig_q  = 1'b0;
					ticks_q = '0;
					phase_q = PH_WAIT;
				end
			end
			PH_WAIT: begin
				ticks_q = sat_inc(ticks_q);
				if (w.echo_level) begin
					ticks_q = '0;
					phase_q = PH_ECHO;
				end else if (ticks_q >= regs_q.timeout_ticks) begin
					trig_q  = 1'b0;
					phase_q = PH_TIMEOUT;
				end
			end
			PH_ECHO: begin
				ticks_q = sat_inc(ticks_q);
				if (!w.echo_level) begin
					width_us_q = {4'd0, ticks_q} * {16'd0, regs_q.tick_us};
					phase_q    = PH_READY;
				end else if (ticks_q >= regs_q.timeout_ticks) begin
					phase_q = PH_TIMEOUT;
				end
			end
			default: ;
		endcase
		if (w.cmd == CMD_START) begin
			if (phase_q == PH_IDLE) begin
				width_us_q = '0;
				ticks_q    = '0;
				trig_q     = 1'b1;
				phase_q    = PH_TRIG;
			end
		end else if (w.cmd == CMD_COLLECT) begin
			if (phase_q == PH_READY) begin
				r.collect_ok = 1'b1;
				r.echo_us    = width_us_q;
				phase_q      = PH_IDLE;
			end else if (phase_q == PH_TIMEOUT) begin
				phase_q = PH_IDLE;
			end
		end
		r.trig_level = trig_q;
		r.phase      = phase_q;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		result_t got;
		result_t want;
		if (!arst_n) begin
			regs_q.trigger_ticks = TRIGGER_TICKS_RST;
			regs_q.timeout_ticks = TIMEOUT_TICKS_RST;
			regs_q.tick_us       = TICK_US_RST;
			phase_q      = PH_IDLE;
			ticks_q      = '0;
			width_us_q   = '0;
			trig_q       = 1'b0;
			words_seen   = 0;
			mismatches   = 0;
			pending_readings.delete();
			readings_due = 0;
		end else begin
			// Retire the output word before queueing this edge's prediction.
			if (m_tvalid && m_tready) begin
				got = m_tdata[24:0];
				if (pending_readings.size() == 0) begin
					if (mismatches < 10) begin
						$write("word %0d: nothing expected, ", words_seen);
						$display("saw trig=%0b phase=%0d ok=%0b us=%0d",
							got.trig_level, got.phase, got.collect_ok, got.echo_us);
					end
					mismatches++;
				end else begin
					want = pending_readings.pop_front();
					if (got.trig_level !== want.trig_level || got.phase !== want.phase ||
							got.collect_ok !== want.collect_ok || got.echo_us !== want.echo_us) begin
						if (mismatches < 10) begin
							$write("word %0d: want trig=%0b phase=%0d ok=%0b us=%0d, ",
								words_seen, want.trig_level, want.phase, want.collect_ok,
								want.echo_us);
							$display("saw trig=%0b phase=%0d ok=%0b us=%0d",
								got.trig_level, got.phase, got.collect_ok, got.echo_us);
						end
						mismatches++;
					end
				end
				words_seen++;
			end
			if (s_tvalid && s_tready)
				pending_readings.push_back(predict_reading(s_tdata[2:0]));
			if (cfg_we) begin
				case (cfg_index)
					REG_TRIGGER_TICKS: regs_q.trigger_ticks = cfg_data[7:0];
					REG_TIMEOUT_TICKS: regs_q.timeout_ticks = cfg_data;
					REG_TICK_US:       regs_q.tick_us       = cfg_data[3:0];
					default: ;
				endcase
			end
			readings_due = pending_readings.size();
		end
	end

endmodule

/* tb/sv/tb_ultrasonic_echo_ranging_fsm.sv */
// Stimulus and verdict for the echo ranging controller. Prediction and
// comparison live in echo_ranging_checker; this module only makes traffic.
module tb_ultrasonic_echo_ranging_fsm;
	import uer_pkg::*;

	localparam int CYCLE_LIMIT = 5_000_000;
	localparam int TOTAL_TICKS = 950;

	// Command code outside the defined set; the block must treat it as none.
	localparam logic [CMD_W-1:0] CMD_SPARE = 2'd3;

	// Receiver stall styles, each held for a random span of cycles.
	typedef enum int {RX_OPEN, RX_COIN, RX_EVERY_THIRD, RX_MOSTLY, RX_BLOCKS} rx_mode_e;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        s_tvalid  = 1'b0;
	logic [7:0]  s_tdata   = '0;   // [1:0] cmd, [2] echo_level, [7:3] zero
	logic        m_tready  = 1'b0;
	logic        cfg_we    = 1'b0;
	logic [1:0]  cfg_index = REG_TRIGGER_TICKS;
	logic [15:0] cfg_data  = '0;
	logic        s_tready;
	logic        m_tvalid;
	logic [31:0] m_tdata;          // [0] trig_level, [3:1] phase, [4] collect_ok,
	                               // [24:5] echo_us, [31:25] zero

	int mismatches;
	int readings_due;
	int cycles         = 0;
	int ticks_sent     = 0;
	int ping_count     = 0;
	int settings_count = 0;
	int burst_left     = 0;

	// Register values currently in force, used to shape well-formed pings.
	logic [7:0]  trig_cfg;
	logic [15:0] timeout_cfg;
	logic [3:0]  tick_cfg;

	rx_mode_e rx_mode    = RX_OPEN;
	int       rx_span    = 0;
	int       rx_hold    = 0;

	initial begin
		forever #5 clk = ~clk;
	end

	ultrasonic_echo_ranging_fsm u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	echo_ranging_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.mismatches  (mismatches),
		.readings_due(readings_due)
	);

	// Hard stop: a hung handshake ends the run as a failure.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("ultrasonic_echo_ranging_fsm: mismatch");
			$finish;
		end
	end

	// Receiver back-pressure: switch style every so often so stalls land on
	// every phase of the ranging cycle, with open stretches in between.
	always @(posedge clk) begin
		if (rx_span == 0) begin
			rx_mode = rx_mode_e'($urandom_range(0, 4));
			rx_span = $urandom_range(16, 200);
		end else begin
			rx_span--;
		end
		case (rx_mode)
			RX_OPEN:        m_tready <= 1'b1;
			RX_COIN:        m_tready <= 1'($urandom_range(0, 1));
			RX_EVERY_THIRD: m_tready <= (rx_span % 3 == 0);
			RX_MOSTLY:      m_tready <= ($urandom_range(0, 7) != 0);
			default: begin
				// hold off for a block of cycles, then take one word
				if (rx_hold == 0) begin
					rx_hold = $urandom_range(1, 12);
					m_tready <= 1'b1;
				end else begin
					rx_hold--;
					m_tready <= 1'b0;
				end
			end
		endcase
	end

	// Send one tick word; bursts of random length with idle gaps between them.
	task automatic push_tick(input logic [CMD_W-1:0] cmd, input logic echo);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 48);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		s_tvalid <= 1'b1;
		s_tdata  <= {5'd0, echo, cmd};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		ticks_sent++;
	endtask

	// Mostly none; now and then a start, collect or spare code that the
	// busy phases must ignore.
	function automatic logic [CMD_W-1:0] stray_cmd();
		int pick;
		pick = $urandom_range(0, 15);
		if (pick == 0)
			return CMD_START;
		if (pick == 1)
			return CMD_COLLECT;
		if (pick == 2)
			return CMD_SPARE;
		return CMD_NONE;
	endfunction

	// One measurement: start, ride out the trigger, wait rise_wait ticks with
	// the echo low, hold it high for width ticks, drop it, linger, collect.
	// A rise_wait or width past the timeout lands in the timeout phase.
	task automatic ping_cycle(input int rise_wait, input int width, input int linger);
		int n;
		push_tick(CMD_START, 1'($urandom_range(0, 1)));
		for (n = 0; n < ((trig_cfg == 0) ? 1 : trig_cfg); n++)
			push_tick(stray_cmd(), 1'($urandom_range(0, 1)));
		for (n = 0; n < rise_wait; n++)
			push_tick(stray_cmd(), 1'b0);
		for (n = 0; n < width; n++)
			push_tick(stray_cmd(), 1'b1);
		push_tick(CMD_NONE, 1'b0);
		// a start while ready or timed out must be dropped
		for (n = 0; n < linger; n++)
			push_tick((n == 0) ? CMD_START : CMD_NONE, 1'($urandom_range(0, 1)));
		push_tick(CMD_COLLECT, 1'($urandom_range(0, 1)));
		ping_count++;
	endtask

	task automatic random_noise(input int count);
		logic [CMD_W-1:0] raw;
		repeat (count) begin
			raw = CMD_W'($urandom_range(0, 3));
			push_tick(raw, 1'($urandom_range(0, 1)));
		end
	endtask

	// Drain the result stream, then rewrite all three registers back to back.
	task automatic program_ranger(input logic [7:0] trig, input logic [15:0] timeout,
			input logic [3:0] tick);
		s_tvalid   <= 1'b0;
		burst_left = 0;
		@(posedge clk);
		while (readings_due != 0) @(posedge clk);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= REG_TRIGGER_TICKS;
		cfg_data  <= {8'd0, trig};
		@(posedge clk);
		cfg_index <= REG_TIMEOUT_TICKS;
		cfg_data  <= timeout;
		@(posedge clk);
		cfg_index <= REG_TICK_US;
		cfg_data  <= {12'd0, tick};
		@(posedge clk);
		cfg_we <= 1'b0;
		trig_cfg    = trig;
		timeout_cfg = timeout;
		tick_cfg    = tick;
		settings_count++;
	endtask

	initial begin : stimulus
		int target;
		int span;
		int pings;
		logic [7:0]  trig_pick;
		logic [15:0] timeout_pick;
		logic [3:0]  tick_pick;

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		trig_cfg    = TRIGGER_TICKS_RST;
		timeout_cfg = TIMEOUT_TICKS_RST;
		tick_cfg    = TICK_US_RST;

		// Reset values: collect while idle, spare command code, a clean ping.
		push_tick(CMD_COLLECT, 1'b1);
		push_tick(CMD_SPARE, 1'b1);
		ping_cycle(2, 3, 1);

		// Tight timeout: time out waiting for the rise, then while echo is high.
		program_ranger(8'd1, 16'd2, 4'd15);
		ping_cycle(5, 0, 1);
		ping_cycle(0, 4, 2);
		ping_cycle(1, 1, 1);

		// All-zero registers: shortest trigger, instant timeout, zero width.
		program_ranger(8'd0, 16'd0, 4'd0);
		ping_cycle(0, 2, 1);
		ping_cycle(1, 0, 1);

		// Longest trigger, longest timeout and largest tick size.
		program_ranger(8'd255, 16'd65535, 4'd15);
		ping_cycle(0, 60, 1);

		// Random part: settings change every few pings, pings dominate, noise
		// words in between push commands into every phase.
		target = TOTAL_TICKS;
		while (ticks_sent < target) begin
			case ($urandom_range(0, 9))
				0:       trig_pick = 8'd255;
				1, 2:    trig_pick = 8'd1;
				default: trig_pick = 8'($urandom_range(1, 6));
			endcase
			case ($urandom_range(0, 5))
				0:       timeout_pick = 16'd1;
				1:       timeout_pick = 16'd65535;
				default: timeout_pick = 16'($urandom_range(2, 30));
			endcase
			case ($urandom_range(0, 3))
				0:       tick_pick = 4'd1;
				1:       tick_pick = 4'd15;
				default: tick_pick = 4'($urandom_range(1, 15));
			endcase
			program_ranger(trig_pick, timeout_pick, tick_pick);
			span  = (timeout_cfg < 30) ? timeout_cfg + 1 : 20;
			pings = (trig_cfg == 8'd255) ? 2 : 8;
			repeat (pings) begin
				if (ticks_sent < target) begin
					if ($urandom_range(0, 3) == 0)
						random_noise($urandom_range(1, 6));
					else
						ping_cycle($urandom_range(0, span), $urandom_range(1, span),
							$urandom_range(1, 3));
				end
			end
		end

		// Let the last results drain, then allow the output stage to settle.
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (readings_due != 0) @(posedge clk);
		repeat (4) @(posedge clk);

		$display("covered %0d tick words in %0d ranging cycles under %0d register settings,",
			ticks_sent, ping_count, settings_count);
		$display("zero and full-scale registers, both timeouts and back-pressure included");
		if (mismatches == 0 && readings_due == 0)
			$display("ultrasonic_echo_ranging_fsm: match");
		else
			$display("ultrasonic_echo_ranging_fsm: mismatch");
		$finish;
	end

endmodule
